@@ rtl/core/wave_equation_string_step_macros.svh @@
// Assertion macros shared by the checker of the string step engine
`ifndef WAVE_EQUATION_STRING_STEP_MACROS_SVH
`define WAVE_EQUATION_STRING_STEP_MACROS_SVH

// same-cycle implication, disabled in reset
`define WES_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wes_pkg.sv @@
// Types and constants of the string step engine
package wes_pkg;

  localparam int VAL_W   = 18;
  localparam int IDX_W   = 9;
  localparam int OP_W    = 2;
  localparam int RATIO_W = 16;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd16384;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam int FIRST_SHIFT = 15;
  localparam int LEAP_SHIFT  = 14;

  localparam int LAP_W  = VAL_W + 2;
  localparam int PROD_W = LAP_W + RATIO_W + 1;
  localparam int RND_W  = PROD_W + 1;
  localparam int D_W    = RND_W - LEAP_SHIFT;
  localparam int BASE_W = VAL_W + 2;
  localparam int SUM_W  = D_W + 1;

  localparam logic signed [RND_W-1:0] RND_FIRST = 1 <<< (FIRST_SHIFT - 1);
  localparam logic signed [RND_W-1:0] RND_LEAP  = 1 <<< (LEAP_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX   = SUM_W'(VAL_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN   = SUM_W'(VAL_MIN);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_FIRST  = 2'd1,
    OP_LEAP   = 2'd2,
    OP_ROTATE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_LAP,
    ST_MUL,
    ST_RND,
    ST_FIN,
    ST_COPY
  } state_t;

  typedef logic [1:0] bank_t;

  localparam int    NUM_BANKS         = 3;
  localparam bank_t BANK_OLDER_RESET   = 2'd0;
  localparam bank_t BANK_CURRENT_RESET = 2'd1;
  localparam bank_t BANK_NEXT_RESET    = 2'd2;

endpackage

@@ rtl/core/wes_ram.sv @@
// Generic simple dual-port RAM with registered read
module wes_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/wave_equation_string_step.sv @@
// Top level of the string step engine: row memories, sequencer and stencil datapath
//
// Finite-difference step engine for a string with fixed ends. Three row banks
// (older, current and next) of GRID_POINTS Q3.14 entries sit in RAMs with one read
// port each. The role of each bank is held in pointers. Items are taken one at a
// time, only in the idle state, and are handled as follows:
//   - Load, end point, out-of-range and similar items go from idle to the result.
//   - A stencil point is paced by the three neighbor reads through the
//     one read port of the source row, followed by the multiply, round and
//     saturate stages.
//   - Rotate copies the next row into the freed bank one entry per cycle.
// After reset a clearing pass over all GRID_POINTS addresses zeroes all banks while
// in_stall stays high. Configuration writes are taken at any time.
module wave_equation_string_step
  import wes_pkg::*;
#(
  parameter int GRID_POINTS = 512
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         op,
  input  logic [IDX_W-1:0]        point_index,
  input  logic signed [VAL_W-1:0] load_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        point_index_res,
  output logic signed [VAL_W-1:0] displacement,
  output logic                    saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [RATIO_W-1:0]      courant_sq
);

  localparam int AW = $clog2(GRID_POINTS);
  localparam int CW = $clog2(GRID_POINTS + 1);
  localparam int XW = IDX_W + AW;

  localparam logic [XW-1:0] GP_EXT   = XW'(GRID_POINTS);
  localparam logic [CW-1:0] CNT_LAST = CW'(GRID_POINTS - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(GRID_POINTS);

  state_t state, state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_m1;
  bank_t ptr_older, ptr_cur, ptr_next;
  logic [RATIO_W-1:0] ratio;

  op_t            op_in, cur_op;
  logic [XW-1:0]  idx_ext;
  logic [AW-1:0]  in_addr, addr_q;
  logic           in_range, in_end, in_stencil, accept, out_free;
  logic [IDX_W-1:0] idx_q;
  logic           calc;
  logic signed [VAL_W-1:0] res_disp;

  logic [AW-1:0]    rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic             wr_en, clear_all;
  bank_t            wr_bank;
  logic [VAL_W-1:0] bank_rd [2**$bits(bank_t)];
  logic [NUM_BANKS-1:0] bank_we;

  logic signed [VAL_W-1:0]   src_data, older_data;
  logic signed [VAL_W-1:0]   a, c, o;
  logic signed [LAP_W-1:0]   lap, lap_calc;
  logic signed [RATIO_W:0]   ratio_s;
  logic signed [PROD_W-1:0]  prod;
  logic signed [RND_W-1:0]   rnd_sum;
  logic signed [D_W-1:0]     d;
  logic signed [BASE_W-1:0]  base;
  logic signed [SUM_W-1:0]   total;
  logic signed [VAL_W-1:0]   clip_val;
  logic                      clip_sat;

  assign op_in      = op_t'(op);
  assign idx_ext    = {{AW{1'b0}}, point_index};
  assign in_addr    = idx_ext[AW-1:0];
  assign in_range   = idx_ext < GP_EXT;
  assign in_end     = (idx_ext == '0) || (idx_ext == GP_EXT - 1'b1);
  assign in_stencil = ((op_in == OP_FIRST) || (op_in == OP_LEAP)) && in_range && !in_end;
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign cnt_m1     = cnt - 1'b1;
  assign cfg_ready  = 1'b1;

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    assign bank_we[g] = clear_all || (wr_en && (wr_bank == bank_t'(g)));
    wes_ram #(
      .WIDTH(VAL_W),
      .DEPTH(GRID_POINTS)
    ) u_ram (
      .clk  (clk),
      .we   (bank_we[g]),
      .waddr(wr_addr),
      .wdata(wr_data),
      .raddr(rd_addr),
      .rdata(bank_rd[g])
    );
  end

  for (genvar g = NUM_BANKS; g < 2**$bits(bank_t); g++) begin : g_unused
    assign bank_rd[g] = '0;
  end

  assign src_data   = $signed(bank_rd[(cur_op == OP_FIRST) ? ptr_older : ptr_cur]);
  assign older_data = $signed(bank_rd[ptr_older]);
  assign ratio_s    = $signed({1'b0, ratio});
  assign lap_calc   = LAP_W'(a) + LAP_W'(src_data) - (LAP_W'(c) <<< 1);
  assign rnd_sum    = RND_W'(prod) + ((cur_op == OP_FIRST) ? RND_FIRST : RND_LEAP);
  assign total      = SUM_W'(d) + SUM_W'(base);

  always_comb begin
    clip_val = total[VAL_W-1:0];
    clip_sat = 1'b0;
    if (total > SUM_MAX) begin
      clip_val = VAL_MAX;
      clip_sat = 1'b1;
    end else if (total < SUM_MIN) begin
      clip_val = VAL_MIN;
      clip_sat = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (cnt == CNT_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (op_in == OP_ROTATE) begin
            state_next = ST_COPY;
          end else if (in_stencil) begin
            state_next = ST_RD1;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_LAP;
      ST_LAP:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_RND;
      ST_RND:  state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      ST_COPY: if (cnt == CNT_END) state_next = ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    rd_addr   = addr_q;
    wr_en     = 1'b0;
    wr_bank   = ptr_older;
    wr_addr   = addr_q;
    wr_data   = '0;
    clear_all = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clear_all = 1'b1;
        wr_addr   = cnt[AW-1:0];
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        rd_addr  = in_addr - 1'b1;
        wr_addr  = in_addr;
        if (in_valid && in_range) begin
          if (op_in == OP_LOAD) begin
            wr_en   = 1'b1;
            wr_bank = ptr_older;
            wr_data = load_value;
          end else if ((op_in != OP_ROTATE) && in_end) begin
            wr_en   = 1'b1;
            wr_bank = (op_in == OP_FIRST) ? ptr_cur : ptr_next;
          end
        end
      end
      ST_RD1: rd_addr = addr_q;
      ST_RD2: rd_addr = addr_q + 1'b1;
      ST_FIN: begin
        if (calc && out_free) begin
          wr_en   = 1'b1;
          wr_bank = (cur_op == OP_FIRST) ? ptr_cur : ptr_next;
          wr_data = clip_val;
        end
      end
      ST_COPY: begin
        rd_addr = cnt[AW-1:0];
        if (cnt != '0) begin
          wr_en   = 1'b1;
          wr_bank = ptr_cur;
          wr_addr = cnt_m1[AW-1:0];
          wr_data = bank_rd[ptr_next];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      ptr_older <= BANK_OLDER_RESET;
      ptr_cur   <= BANK_CURRENT_RESET;
      ptr_next  <= BANK_NEXT_RESET;
      ratio     <= RATIO_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        ratio <= courant_sq;
      end
      if (((state == ST_CLEAR) && (cnt != CNT_LAST)) ||
          ((state == ST_COPY) && (cnt != CNT_END))) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if ((state == ST_IDLE) && accept && (op_in == OP_ROTATE)) begin
        ptr_older <= ptr_cur;
        ptr_cur   <= ptr_older;
      end
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && accept) begin
      cur_op   <= op_in;
      idx_q    <= point_index;
      addr_q   <= in_addr;
      calc     <= in_stencil;
      res_disp <= ((op_in == OP_LOAD) && in_range) ? load_value : '0;
    end
    if (state == ST_RD1) begin
      a <= src_data;
    end
    if (state == ST_RD2) begin
      c <= src_data;
      o <= older_data;
    end
    if (state == ST_LAP) begin
      lap <= lap_calc;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(lap * ratio_s);
    end
    if (state == ST_RND) begin
      d    <= D_W'((cur_op == OP_FIRST) ? (rnd_sum >>> FIRST_SHIFT)
                                        : (rnd_sum >>> LEAP_SHIFT));
      base <= (cur_op == OP_FIRST) ? BASE_W'(o) : (BASE_W'(c) <<< 1) - BASE_W'(o);
    end
    if ((state == ST_FIN) && out_free) begin
      point_index_res <= idx_q;
      displacement    <= calc ? clip_val : res_disp;
      saturated       <= calc && clip_sat;
    end
  end

endmodule

@@ rtl/core/wave_equation_string_step_checker.sv @@
// Port-level assertion checker of the string step engine, bound to the top level
`include "wave_equation_string_step_macros.svh"

module wave_equation_string_step_checker
  import wes_pkg::*;
#(
  parameter int GRID_POINTS = 512
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [IDX_W-1:0]        point_index_res,
  input logic signed [VAL_W-1:0] displacement,
  input logic                    saturated
);

  logic                   in_take;
  logic                   res_held;
  logic [IDX_W+VAL_W:0]   res_bits;
  logic                   at_limit;
  logic                   end_point;
  logic                   past_end;
  logic                   blank_res;

  assign in_take   = in_valid && !in_stall;
  assign res_held  = out_valid && out_stall;
  assign res_bits  = {point_index_res, displacement, saturated};
  assign at_limit  = (displacement == VAL_MAX) || (displacement == VAL_MIN);
  assign end_point = (point_index_res == '0) || (32'(point_index_res) == GRID_POINTS - 1);
  assign past_end  = 32'(point_index_res) >= GRID_POINTS;
  assign blank_res = (displacement == '0) && !saturated;

  `WES_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall, "in_stall low after an item")

  `WES_ASSERT_NEXT(a_out_hold, res_held, out_valid && $stable(res_bits), "stalled result changed")

  `WES_ASSERT_SAME(a_sat_at_limit, out_valid && saturated, at_limit, "clipped value off limit")

  `WES_ASSERT_SAME(a_ends_unclipped, out_valid && end_point, !saturated, "end point clipped")

  `WES_ASSERT_SAME(a_outside_zero, out_valid && past_end, blank_res, "out-of-range result not zero")

endmodule

bind wave_equation_string_step wave_equation_string_step_checker #(
  .GRID_POINTS(GRID_POINTS)
) u_checker (.*);

@@ verif/string_rows_pkg.sv @@
// Row tracker of the string step engine: predicts each result and checks it against the block
package string_rows_pkg;
  import wes_pkg::*;

  localparam int POINTS = 512;

  typedef struct packed {
    logic [IDX_W-1:0]        point;
    logic signed [VAL_W-1:0] disp;
    logic                    sat;
  } point_result_t;

  class string_rows;
    logic signed [VAL_W-1:0] older_row [POINTS];
    logic signed [VAL_W-1:0] current_row [POINTS];
    logic signed [VAL_W-1:0] next_row [POINTS];
    logic [1:0]              rotations;
    logic [RATIO_W-1:0]      ratio;
    point_result_t           awaited_points[$];
    int unsigned             faults;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        current_row[i] = '0;
        next_row[i] = '0;
      end
      rotations = '0;
      ratio = RATIO_RESET;
      faults = 0;
    endfunction

    function int unsigned pending();
      return awaited_points.size();
    endfunction

    function longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function logic signed [VAL_W-1:0] clip_q314(longint sum, output logic clipped);
      clipped = 1'b1;
      if (sum > longint'(VAL_MAX)) return VAL_MAX;
      if (sum < longint'(VAL_MIN)) return VAL_MIN;
      clipped = 1'b0;
      return VAL_W'(sum);
    endfunction

    function logic signed [VAL_W-1:0] first_level_point(int i, output logic clipped);
      longint lap;
      lap = longint'(older_row[i-1]) + longint'(older_row[i+1]) - 2 * longint'(older_row[i]);
      return clip_q314(longint'(older_row[i])
                       + round_shift(longint'(ratio) * lap, FIRST_SHIFT), clipped);
    endfunction

    function logic signed [VAL_W-1:0] leap_level_point(int i, output logic clipped);
      longint lap;
      lap = longint'(current_row[i-1]) + longint'(current_row[i+1])
            - 2 * longint'(current_row[i]);
      return clip_q314(2 * longint'(current_row[i]) - longint'(older_row[i])
                       + round_shift(longint'(ratio) * lap, LEAP_SHIFT), clipped);
    endfunction

    function void accept_item(op_t code, logic [IDX_W-1:0] idx,
                              logic signed [VAL_W-1:0] value);
      point_result_t r;
      logic clipped;
      bit fixed_end;
      fixed_end = (idx == 0) || (int'(idx) == POINTS - 1);
      r.point = idx;
      r.disp = '0;
      r.sat = 1'b0;
      case (code)
        OP_LOAD: begin
          older_row[idx] = value;
          r.disp = value;
        end
        OP_FIRST: begin
          if (!fixed_end) begin
            r.disp = first_level_point(int'(idx), clipped);
            r.sat = clipped;
          end
          current_row[idx] = r.disp;
        end
        OP_LEAP: begin
          if (!fixed_end) begin
            r.disp = leap_level_point(int'(idx), clipped);
            r.sat = clipped;
          end
          next_row[idx] = r.disp;
        end
        default: begin
          older_row = current_row;
          current_row = next_row;
          rotations++;
        end
      endcase
      awaited_points.push_back(r);
    endfunction

    function void compare_point(logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] disp,
                                logic sat);
      point_result_t want;
      if (awaited_points.size() == 0) begin
        $error("result for point %0d with no item outstanding", idx);
        faults++;
        return;
      end
      want = awaited_points.pop_front();
      if (idx !== want.point) begin
        $error("point_index_res: expected %0d, got %0d", want.point, idx);
        faults++;
      end
      if (disp !== want.disp) begin
        $error("displacement: expected %0d, got %0d", want.disp, disp);
        faults++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0b, got %0b", want.sat, sat);
        faults++;
      end
    endfunction
  endclass

endpackage

@@ verif/tb_wave_equation_string_step.sv @@
// Testbench top of the string step engine: stimulus, output stall pattern and final verdict
module tb_wave_equation_string_step;
  timeunit 1ns;
  timeprecision 1ps;

  import wes_pkg::*;
  import string_rows_pkg::*;

  localparam int ITEMS = 1250;
  localparam int PHASES = 7;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        point_index;
  logic signed [VAL_W-1:0] load_value;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IDX_W-1:0]        point_index_res;
  logic signed [VAL_W-1:0] displacement;
  logic                    saturated;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [RATIO_W-1:0]      courant_sq;

  string_rows  rows;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  wave_equation_string_step #(.GRID_POINTS(POINTS)) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .point_index     (point_index),
    .load_value      (load_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .point_index_res (point_index_res),
    .displacement    (displacement),
    .saturated       (saturated),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .courant_sq      (courant_sq)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(op_t code, logic [IDX_W-1:0] idx, logic signed [VAL_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    op <= code;
    point_index <= idx;
    load_value <= value;
    do @(posedge clk); while (in_stall);
    rows.accept_item(code, idx, value);
    items_sent++;
    burst_left--;
  endtask

  // occasionally slip a stray item into a sweep
  task automatic send_sweep_item(op_t code, int idx, logic signed [VAL_W-1:0] value);
    if ($urandom_range(0, 15) == 0)
      send_item(op_t'($urandom_range(0, 3)), IDX_W'($urandom), VAL_W'($urandom));
    send_item(code, IDX_W'(idx), value);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (rows.pending() != 0) @(posedge clk);
    repeat (POINTS + 16) @(posedge clk);
  endtask

  task automatic write_ratio(logic [RATIO_W-1:0] value);
    cfg_valid <= 1'b1;
    courant_sq <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rows.ratio = value;
  endtask

  task automatic run_random(int unsigned goal);
    int lo, hi, w, walk, profile, levels;
    while (items_sent < goal) begin
      w = $urandom_range(2, 24);
      lo = $urandom_range(0, POINTS - 1 - w);
      if ($urandom_range(0, 4) == 0) lo = 0;
      hi = lo + w;
      if ($urandom_range(0, 4) == 0) begin
        hi = POINTS - 1;
        lo = hi - w;
      end
      profile = $urandom_range(0, 3);
      walk = int'($urandom_range(0, 40000)) - 20000;
      for (int i = (lo > 0 ? lo - 1 : lo); i <= (hi < POINTS - 1 ? hi + 1 : hi); i++) begin
        case (profile)
          0: walk = walk + int'($urandom_range(0, 2000)) - 1000;
          1: begin
            walk = walk + int'($urandom_range(0, 32000)) - 16000;
            if (walk > int'(VAL_MAX)) walk = int'(VAL_MAX);
            if (walk < int'(VAL_MIN)) walk = int'(VAL_MIN);
          end
          2: walk = int'($urandom_range(0, 262143)) - 131072;
          default: begin
            case ($urandom_range(0, 3))
              0: walk = int'(VAL_MAX);
              1: walk = int'(VAL_MIN);
              2: walk = -1;
              default: walk = 0;
            endcase
          end
        endcase
        send_sweep_item(OP_LOAD, i, VAL_W'(walk));
      end
      for (int i = lo; i <= hi; i++)
        send_sweep_item(OP_FIRST, i, VAL_W'($urandom));
      levels = $urandom_range(1, 4);
      for (int k = 0; k < levels; k++) begin
        if ($urandom_range(0, 9) != 0)
          send_sweep_item(OP_ROTATE, $urandom_range(0, POINTS - 1), VAL_W'($urandom));
        for (int i = lo; i <= hi; i++)
          send_sweep_item(OP_LEAP, i, VAL_W'($urandom));
      end
      send_sweep_item(OP_ROTATE, $urandom_range(0, POINTS - 1), VAL_W'($urandom));
    end
  endtask

  // compare each result taken from the block, and drive the output stall in changing modes
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      rows.compare_point(point_index_res, displacement, saturated);
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    logic [RATIO_W-1:0] r;
    rows = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_LOAD;
    point_index <= '0;
    load_value <= '0;
    cfg_valid <= 1'b0;
    courant_sq <= RATIO_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_FIRST, 9'd0, VAL_MAX);
    send_item(OP_LEAP, 9'd511, VAL_MIN);
    send_item(OP_ROTATE, 9'd511, VAL_MAX);
    send_item(OP_LOAD, 9'd0, VAL_MIN);
    send_item(OP_LOAD, 9'd511, VAL_MAX);
    send_item(OP_LOAD, 9'd1, VAL_MAX);
    send_item(OP_LOAD, 9'd2, VAL_MIN);
    send_item(OP_LOAD, 9'd3, VAL_MAX);
    send_item(OP_LOAD, 9'd4, -18'sd1);
    send_item(OP_LOAD, 9'd5, '0);
    send_item(OP_LOAD, 9'd256, 18'h15555);
    send_item(OP_LOAD, 9'd257, 18'h2AAAA);
    send_item(OP_FIRST, 9'd1, '0);
    send_item(OP_FIRST, 9'd2, '0);
    send_item(OP_FIRST, 9'd3, '0);
    send_item(OP_FIRST, 9'd4, '0);
    send_item(OP_FIRST, 9'd256, '0);
    send_item(OP_ROTATE, 9'd0, '0);
    send_item(OP_LEAP, 9'd1, '0);
    send_item(OP_LEAP, 9'd2, '0);
    send_item(OP_LEAP, 9'd3, '0);
    send_item(OP_LEAP, 9'd4, '0);
    send_item(OP_LEAP, 9'd0, '0);
    send_item(OP_FIRST, 9'd511, '0);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: r = 16'd32768;
        1: r = 16'd0;
        2: r = 16'hFFFF;
        3: r = 16'd1;
        6: r = RATIO_RESET;
        default: r = RATIO_W'($urandom);
      endcase
      write_ratio(r);
      run_random((p + 1) * ITEMS / PHASES);
    end
    drain_results();

    if (rows.faults == 0 && rows.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ wave_equation_string_step.f @@
+incdir+rtl/core
rtl/core/wes_pkg.sv
rtl/core/wes_ram.sv
rtl/core/wave_equation_string_step.sv
rtl/core/wave_equation_string_step_checker.sv
verif/string_rows_pkg.sv
verif/tb_wave_equation_string_step.sv
